### sv/tmt_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the tiled matrix transpose core.
// No dependencies; imported by tmt_ram and tiled_matrix_transpose_core.
package tmt_pkg;

    localparam int DEF_TILE_EDGE = 8;
    localparam int DEF_MAX_DIM   = 4096;

    // Field widths of the stream items and the configuration registers.
    localparam int DIM_W   = 13;
    localparam int POS_W   = 12;
    localparam int VALUE_W = 32;
    localparam int OUT_DATA_W = VALUE_W + 2 * POS_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

endpackage

### sv/tmt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on tmt_pkg for the defaults of its width and depth.
module tmt_ram
    import tmt_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = DEF_TILE_EDGE * DEF_TILE_EDGE
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/tiled_matrix_transpose_core.sv
`timescale 1ns / 1ps
// Channel  | Direction | Payload                                   | Handshake
// s_axis   | in        | tdata[31:0] element                       | s_tvalid/s_tready
// m_axis   | out       | tdata value,dest_row,dest_col; tlast tile | m_tvalid/m_tready
//          |           | done; tuser matrix done                   |
// cfg      | in        | cfg_index register, cfg_data value        | cfg_valid/cfg_ready
//
// Loading takes one element per cycle; the request that completes a tile starts the drain.
// Draining a tile of R x C valid elements takes a tile RAM read and then a capture per element,
// during which no input is accepted; output stalls hold the drain before the tile RAM read.
// Reset returns the position to the first element and both dimensions to one.
// A configuration write is taken only while loading and holds off the input for that cycle;
// a write to either dimension restarts at the first element and drops a partial tile.
// Depends on tmt_pkg and tmt_ram.
module tiled_matrix_transpose_core
    import tmt_pkg::*;
#(
    parameter int TILE_EDGE = DEF_TILE_EDGE,
    parameter int MAX_DIM   = DEF_MAX_DIM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_W-1:0]    s_tdata,   // [31:0] element
    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] value, [43:32] dest_row, [55:44] dest_col
    output logic                  m_tlast,   // tile_done
    output logic                  m_tuser,   // [0] matrix_done
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIM_W-1:0]      cfg_data
);

    localparam int IDX_W  = $clog2(TILE_EDGE);
    localparam int ADDR_W = $clog2(TILE_EDGE * TILE_EDGE);

    typedef enum logic [1:0] {S_LOAD, S_RD, S_CAP} state_t;

    state_t                  state_reg, state_next;
    logic [DIM_W-1:0]        num_rows_reg, num_rows_next;
    logic [DIM_W-1:0]        num_cols_reg, num_cols_next;
    logic [DIM_W-1:0]        row_base_reg, row_base_next;
    logic [DIM_W-1:0]        col_base_reg, col_base_next;
    logic [IDX_W-1:0]        in_row_reg, in_row_next;
    logic [IDX_W-1:0]        in_col_reg, in_col_next;
    logic [IDX_W-1:0]        dr_row_reg, dr_row_next;
    logic [IDX_W-1:0]        dr_col_reg, dr_col_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_user_reg, out_user_next;

    logic [DIM_W-1:0]   rows_rem, cols_rem;
    logic [IDX_W-1:0]   last_r, last_c;
    logic [DIM_W:0]     row_base_adv, col_base_adv;
    logic               row_last_tile, col_last_tile;
    logic               wr_en, rd_en, out_free, in_end, drain_end;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic [DIM_W-1:0]   src_row, src_col, cfg_dim;

    // Extent of the current tile, as the last valid in-tile index.
    assign rows_rem = num_rows_reg - row_base_reg;
    assign cols_rem = num_cols_reg - col_base_reg;
    assign last_r = (rows_rem >= DIM_W'(TILE_EDGE)) ? IDX_W'(TILE_EDGE - 1)
                                                    : IDX_W'(rows_rem - DIM_W'(1));
    assign last_c = (cols_rem >= DIM_W'(TILE_EDGE)) ? IDX_W'(TILE_EDGE - 1)
                                                    : IDX_W'(cols_rem - DIM_W'(1));

    assign row_base_adv  = {1'b0, row_base_reg} + (DIM_W+1)'(TILE_EDGE);
    assign col_base_adv  = {1'b0, col_base_reg} + (DIM_W+1)'(TILE_EDGE);
    assign row_last_tile = row_base_adv >= {1'b0, num_rows_reg};
    assign col_last_tile = col_base_adv >= {1'b0, num_cols_reg};

    // A pending register write goes first, so the element lands at the restarted position.
    assign s_tready  = (state_reg == S_LOAD) && !cfg_valid;
    assign cfg_ready = (state_reg == S_LOAD);
    assign wr_en     = s_tvalid && s_tready;
    assign wr_addr   = ADDR_W'(in_row_reg) * ADDR_W'(TILE_EDGE) + ADDR_W'(in_col_reg);
    assign rd_addr   = ADDR_W'(dr_row_reg) * ADDR_W'(TILE_EDGE) + ADDR_W'(dr_col_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign rd_en     = (state_reg == S_RD) && out_free;
    assign in_end    = (in_row_reg == last_r) && (in_col_reg == last_c);
    assign drain_end = (dr_row_reg == last_r) && (dr_col_reg == last_c);
    assign src_row   = row_base_reg + DIM_W'(dr_row_reg);
    assign src_col   = col_base_reg + DIM_W'(dr_col_reg);

    // A dimension of zero counts as one, and anything above MAX_DIM as MAX_DIM.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_dim = DIM_W'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_DIM))
        begin
            cfg_dim = DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_dim = cfg_data;
        end
    end

    tmt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TILE_EDGE * TILE_EDGE)
    ) u_tile_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        num_rows_next  = num_rows_reg;
        num_cols_next  = num_cols_reg;
        row_base_next  = row_base_reg;
        col_base_next  = col_base_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        dr_row_next    = dr_row_reg;
        dr_col_next    = dr_col_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (wr_en)
                begin
                    if (in_end)
                    begin
                        in_row_next = '0;
                        in_col_next = '0;
                        dr_row_next = '0;
                        dr_col_next = '0;
                        state_next  = S_RD;
                    end
                    else if (in_col_reg == last_c)
                    begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + IDX_W'(1);
                    end
                    else
                    begin
                        in_col_next = in_col_reg + IDX_W'(1);
                    end
                end
            end
            S_RD:
            begin
                if (rd_en)
                begin
                    state_next = S_CAP;
                end
            end
            S_CAP:
            begin
                // The read was only issued with the output register free, so it is free now.
                out_valid_next = 1'b1;
                out_data_next  = {src_row[POS_W-1:0], src_col[POS_W-1:0], rd_data};
                out_last_next  = drain_end;
                out_user_next  = drain_end && row_last_tile && col_last_tile;
                if (dr_row_reg == last_r)
                begin
                    dr_row_next = '0;
                    dr_col_next = dr_col_reg + IDX_W'(1);
                end
                else
                begin
                    dr_row_next = dr_row_reg + IDX_W'(1);
                end
                if (drain_end)
                begin
                    state_next = S_LOAD;
                    if (col_last_tile)
                    begin
                        col_base_next = '0;
                        row_base_next = row_last_tile ? '0 : row_base_adv[DIM_W-1:0];
                    end
                    else
                    begin
                        col_base_next = col_base_adv[DIM_W-1:0];
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS:
                begin
                    num_rows_next = cfg_dim;
                end
                REG_NUM_COLS:
                begin
                    num_cols_next = cfg_dim;
                end
                default:
                begin
                end
            endcase
            if (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS)
            begin
                row_base_next = '0;
                col_base_next = '0;
                in_row_next   = '0;
                in_col_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            num_rows_reg  <= DIM_W'(1);
            num_cols_reg  <= DIM_W'(1);
            row_base_reg  <= '0;
            col_base_reg  <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            dr_row_reg    <= '0;
            dr_col_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_rows_reg  <= num_rows_next;
            num_cols_reg  <= num_cols_next;
            row_base_reg  <= row_base_next;
            col_base_reg  <= col_base_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            dr_row_reg    <= dr_row_next;
            dr_col_reg    <= dr_col_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            out_user_reg  <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    a_load_in_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (in_row_reg <= last_r) && (in_col_reg <= last_c))
        else $error("load position outside the tile extent");

    a_drain_in_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> (dr_row_reg <= last_r) && (dr_col_reg <= last_c))
        else $error("drain position outside the tile extent");

    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAP) |-> !out_valid_reg)
        else $error("capture into an occupied output register");

    a_read_then_capture: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == S_CAP))
        else $error("tile read not followed by capture");

    a_matrix_ends_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg) |-> out_last_reg)
        else $error("matrix end without tile end");

endmodule

### tb/sv/tiled_matrix_transpose_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tiled_matrix_transpose_core: streams source elements,
// predicts every transposed result in-line and checks each one as it leaves the core.
// Depends on tmt_pkg and the core RTL (tiled_matrix_transpose_core, tmt_ram).
module tiled_matrix_transpose_core_tb;
    import tmt_pkg::*;

    localparam int TILE         = DEF_TILE_EDGE;
    localparam int DIM_LIMIT    = DEF_MAX_DIM;
    localparam int IDLE_WAIT    = 8;
    localparam int TAIL_WAIT    = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 450;

    // Register indexes that the core does not implement; writes to them change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   dest_row;
        logic [POS_W-1:0]   dest_col;
        logic               tile_done;
        logic               matrix_done;
    } turned_elem_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_data;

    // Predictor state: a copy of the tile store, the position and the dimensions in use.
    logic [VALUE_W-1:0] tile_copy [TILE*TILE];
    int unsigned        rows_used;
    int unsigned        cols_used;
    int unsigned        tile_row_at;
    int unsigned        tile_col_at;
    int unsigned        row_in_tile;
    int unsigned        col_in_tile;

    turned_elem_t turned_queue [$];
    turned_elem_t seen_elem;
    turned_elem_t want_elem;
    int unsigned  mismatches;
    int unsigned  cycle_count;

    // Sender burst and receiver stall controls.
    int unsigned burst_max;
    int unsigned gap_max;
    int unsigned burst_left;
    int unsigned stall_pct;
    int unsigned stall_max;
    int unsigned stall_left;

    tiled_matrix_transpose_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("%0t ns: run did not finish, %0d results still expected",
                     $realtime, turned_queue.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: ready most of the time, with stalls of random length when enabled.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, stall_max);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            seen_elem.value       = m_tdata[31:0];
            seen_elem.dest_row    = m_tdata[43:32];
            seen_elem.dest_col    = m_tdata[55:44];
            seen_elem.tile_done   = m_tlast;
            seen_elem.matrix_done = m_tuser;
            if (turned_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: expected none, actual %h %0d %0d %b %b",
                         $realtime, seen_elem.value, seen_elem.dest_row,
                         seen_elem.dest_col, seen_elem.tile_done, seen_elem.matrix_done);
            end
            else
            begin
                want_elem = turned_queue.pop_front();
                if (seen_elem !== want_elem)
                begin
                    mismatches++;
                    $display("%0t ns: expected %h %0d %0d %b %b, actual %h %0d %0d %b %b",
                             $realtime, want_elem.value, want_elem.dest_row,
                             want_elem.dest_col, want_elem.tile_done,
                             want_elem.matrix_done, seen_elem.value, seen_elem.dest_row,
                             seen_elem.dest_col, seen_elem.tile_done,
                             seen_elem.matrix_done);
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > DIM_LIMIT)
            return DIM_LIMIT;
        return 32'(raw);
    endfunction

    function automatic int unsigned tile_extent(input int unsigned dim, input int unsigned idx);
        int unsigned base;
        int unsigned rem;
        base = idx * TILE;
        rem  = (dim > base) ? dim - base : 1;
        return (rem < TILE) ? rem : TILE;
    endfunction

    task automatic rewind_to_first();
        tile_row_at = 0;
        tile_col_at = 0;
        row_in_tile = 0;
        col_in_tile = 0;
    endtask

    // Stores one accepted element and, when it completes a tile, queues the tile transposed.
    task automatic predict_transpose(input logic [VALUE_W-1:0] elem);
        int unsigned  n_tile_rows;
        int unsigned  n_tile_cols;
        int unsigned  vr;
        int unsigned  vc;
        int unsigned  src_row;
        int unsigned  src_col;
        bit           last_tile;
        turned_elem_t t;
        n_tile_rows = (rows_used - 1) / TILE + 1;
        n_tile_cols = (cols_used - 1) / TILE + 1;
        if (tile_row_at >= n_tile_rows || tile_col_at >= n_tile_cols)
            rewind_to_first();
        vr = tile_extent(rows_used, tile_row_at);
        vc = tile_extent(cols_used, tile_col_at);
        if (row_in_tile >= vr || col_in_tile >= vc)
            rewind_to_first();
        tile_copy[(row_in_tile * TILE + col_in_tile) % (TILE * TILE)] = elem;
        if (row_in_tile != vr - 1 || col_in_tile != vc - 1)
        begin
            col_in_tile++;
            if (col_in_tile >= vc)
            begin
                col_in_tile = 0;
                row_in_tile++;
            end
            return;
        end
        last_tile = (tile_row_at == n_tile_rows - 1) && (tile_col_at == n_tile_cols - 1);
        for (int c = 0; c < vc; c++)
        begin
            for (int r = 0; r < vr; r++)
            begin
                src_row       = tile_row_at * TILE + r;
                src_col       = tile_col_at * TILE + c;
                t.value       = tile_copy[(r * TILE + c) % (TILE * TILE)];
                t.dest_row    = src_col[POS_W-1:0];
                t.dest_col    = src_row[POS_W-1:0];
                t.tile_done   = (c == vc - 1) && (r == vr - 1);
                t.matrix_done = t.tile_done && last_tile;
                turned_queue.push_back(t);
            end
        end
        row_in_tile = 0;
        col_in_tile = 0;
        tile_col_at++;
        if (tile_col_at >= n_tile_cols)
        begin
            tile_col_at = 0;
            tile_row_at++;
            if (tile_row_at >= n_tile_rows)
                tile_row_at = 0;
        end
    endtask

    task automatic set_traffic(input int unsigned b_max, input int unsigned g_max,
                               input int unsigned s_pct, input int unsigned s_max);
        burst_max  = b_max;
        gap_max    = g_max;
        burst_left = $urandom_range(1, b_max);
        stall_pct  = s_pct;
        stall_max  = s_max;
    endtask

    task automatic send_element(input logic [VALUE_W-1:0] elem);
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_transpose(elem);
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            if (gap_max != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
    endtask

    // Waits until every queued result has left, then lets the core finish its own work.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (turned_queue.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] data);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == REG_NUM_ROWS)
        begin
            rows_used = clamp_dim(data);
            rewind_to_first();
        end
        else if (idx == REG_NUM_COLS)
        begin
            cols_used = clamp_dim(data);
            rewind_to_first();
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return '0;
        if (roll < 10)
            return DIM_W'(DIM_LIMIT);
        if (roll < 14)
            return DIM_W'($urandom_range(DIM_LIMIT + 1, 8191));
        if (roll < 18)
            return DIM_W'($urandom);
        return DIM_W'($urandom_range(1, 20));
    endfunction

    // With the reset dimensions of one by one, every element is a whole matrix.
    task automatic test_single_element_matrix();
        set_traffic(4, 0, 0, 0);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
        settle_idle();
    endtask

    // A zero row count acts as one and an oversized column count acts as the maximum.
    // A write to an unimplemented index in the middle of a tile must not move the position.
    task automatic test_dimension_clamp();
        set_traffic(6, 3, 30, 5);
        write_register(REG_NUM_ROWS, '0);
        write_register(REG_NUM_COLS, 13'h1FFF);
        repeat (5) send_element(pick_element());
        write_register(REG_SPARE_2, 13'h1555);
        repeat (13) send_element(pick_element());
        settle_idle();
    endtask

    // The two partial elements left by the previous test are dropped by this write.
    task automatic test_restart_on_write();
        set_traffic(2, 2, 20, 3);
        write_register(REG_NUM_COLS, 13'd3);
        repeat (3) send_element(pick_element());
        settle_idle();
    endtask

    task automatic test_random_matrices();
        int unsigned sent;
        int unsigned n_items;
        int unsigned area;
        int unsigned mode;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                set_traffic($urandom_range(1, 40), 0, 0, 0);
            else
                set_traffic($urandom_range(1, 16), $urandom_range(0, 6),
                            $urandom_range(5, 50), $urandom_range(0, 12));
            mode = $urandom_range(0, 9);
            if (mode < 6)
            begin
                write_register(REG_NUM_ROWS, pick_dim());
                write_register(REG_NUM_COLS, pick_dim());
            end
            else if (mode == 6)
                write_register(REG_NUM_ROWS, pick_dim());
            else if (mode == 7)
                write_register(REG_NUM_COLS, pick_dim());
            else if (mode == 8)
                write_register($urandom_range(0, 1) ? REG_SPARE_3 : REG_SPARE_2,
                               DIM_W'($urandom));
            area = rows_used * cols_used;
            if (area <= 150)
            begin
                n_items = area * $urandom_range(1, 2);
                if ($urandom_range(0, 9) < 3)
                    n_items += $urandom_range(0, area - 1);
            end
            else
                n_items = $urandom_range(1, 70);
            if (n_items > RANDOM_ITEMS - sent)
                n_items = RANDOM_ITEMS - sent;
            repeat (n_items) send_element(pick_element());
            sent += n_items;
        end
        settle_idle();
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_NUM_ROWS;
        cfg_data    = '0;
        mismatches  = 0;
        cycle_count = 0;
        stall_left  = 0;
        set_traffic(1, 0, 0, 0);
        rows_used   = 1;
        cols_used   = 1;
        rewind_to_first();
        foreach (tile_copy[i])
            tile_copy[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element_matrix();
        test_dimension_clamp();
        test_restart_on_write();
        test_random_matrices();

        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && turned_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
